// File: hw/rtl/spc_pkg.sv
// ---------------------------------------------------------------------------
// spc_pkg
// Shared types, constants and saturation helpers of the pixel calibration core.
// ---------------------------------------------------------------------------
package spc_pkg;

   localparam int VAL_W     = 48;
   localparam int RAW_W     = 16;
   localparam int CNT_W     = 32;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [VAL_W-1:0] VAL_MAX   = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [VAL_W-1:0] VAL_MIN   = 48'sh8000_0000_0000;
   localparam logic signed [RAW_W-1:0] BYTE_FILL = -16'sd128;
   localparam logic [CNT_W-1:0]        CNT_MAX   = 32'hFFFF_FFFF;
   localparam logic [31:0]             LN2_Q32   = 32'd2977044472;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE       = 3'd0,
      CSR_FILL_CODE  = 3'd1,
      CSR_SCALE      = 3'd2,
      CSR_OFFSET     = 3'd3,
      CSR_GAIN       = 3'd4,
      CSR_C2         = 3'd5,
      CSR_BAND_OFF   = 3'd6,
      CSR_BAND_SLOPE = 3'd7
   } spc_csr_type;

   typedef enum logic [1:0] {
      MODE_BYTE   = 2'd0,
      MODE_SCALED = 2'd1,
      MODE_REFL   = 2'd2,
      MODE_THERM  = 2'd3
   } spc_mode_type;

   typedef struct packed {
      spc_mode_type            mode;
      logic signed [RAW_W-1:0] fill_code;
      logic signed [VAL_W-1:0] count_scale;
      logic signed [VAL_W-1:0] count_offset;
      logic signed [VAL_W-1:0] gain_or_first_planck;
      logic signed [VAL_W-1:0] second_planck;
      logic signed [VAL_W-1:0] band_offset;
      logic signed [VAL_W-1:0] band_slope;
   } spc_cfg_type;

   // classified pixel: raw holds the signed count, or the final byte value
   typedef struct packed {
      spc_mode_type            mode;
      logic                    fill;
      logic                    first;
      logic signed [RAW_W-1:0] raw;
   } spc_item_type;

   function automatic logic signed [VAL_W-1:0] sat48(input logic signed [79:0] v);
      logic signed [VAL_W-1:0] r;
      if (v > 80'(VAL_MAX)) r = VAL_MAX;
      else if (v < 80'(VAL_MIN)) r = VAL_MIN;
      else r = v[VAL_W-1:0];
      return r;
   endfunction

   function automatic logic [VAL_W-1:0] mag48(input logic signed [VAL_W-1:0] v);
      logic [VAL_W-1:0] r;
      if (v[VAL_W-1]) r = 48'(48'd0 - v);
      else r = v;
      return r;
   endfunction

   // signed, saturated value from a magnitude and a sign
   function automatic logic signed [VAL_W-1:0] from_mag(input logic [95:0] m, input logic neg);
      logic signed [VAL_W-1:0] r;
      if (neg) begin
         if (m > 96'(48'h8000_0000_0000)) r = VAL_MIN;
         else r = 48'(48'd0 - m[VAL_W-1:0]);
      end else begin
         if (m > 96'(48'h7FFF_FFFF_FFFF)) r = VAL_MAX;
         else r = m[VAL_W-1:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/spc_if.sv
// ---------------------------------------------------------------------------
// spc_if
// Request and response channels of the pixel calibration core.
// ---------------------------------------------------------------------------
interface spc_req_if;
   import spc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [RAW_W-1:0] raw_count;
   logic                    first_of_image;
   modport source (output valid, raw_count, first_of_image, input ready);
   modport sink (input valid, raw_count, first_of_image, output ready);
endinterface

interface spc_rsp_if;
   import spc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] calibrated_value;
   logic                    is_fill;
   logic                    out_of_domain;
   logic signed [VAL_W-1:0] running_min;
   logic signed [VAL_W-1:0] running_max;
   logic [CNT_W-1:0]        fill_total;
   modport source (output valid, calibrated_value, is_fill, out_of_domain,
                   running_min, running_max, fill_total, input ready);
   modport sink (input valid, calibrated_value, is_fill, out_of_domain,
                 running_min, running_max, fill_total, output ready);
endinterface

// File: hw/rtl/spc_front.sv
// ---------------------------------------------------------------------------
// spc_front
// Accepts requests, detects fill pixels and extracts the count for the queue.
// ---------------------------------------------------------------------------
module spc_front #(
   parameter int RAW_WIDTH = 16
) (
   spc_req_if.sink             req,
   input  spc_pkg::spc_cfg_type cfg,
   input  logic                q_full,
   output logic                q_push,
   output spc_pkg::spc_item_type q_item
);
   import spc_pkg::*;

   logic signed [RAW_WIDTH-1:0] raw_n;
   logic signed [RAW_WIDTH-1:0] fill_n;
   logic signed [7:0]           byte_v;
   logic                        byte_fill;
   logic                        word_fill;

   assign raw_n     = req.raw_count[RAW_WIDTH-1:0];
   assign fill_n    = cfg.fill_code[RAW_WIDTH-1:0];
   assign byte_v    = req.raw_count[7:0];
   assign byte_fill = (req.raw_count[7:0] == cfg.fill_code[7:0]);
   assign word_fill = (raw_n == fill_n);

   assign req.ready = !q_full;
   assign q_push    = req.valid && !q_full;

   always_comb begin
      q_item.mode  = cfg.mode;
      q_item.first = req.first_of_image;
      if (cfg.mode == MODE_BYTE) begin
         q_item.fill = byte_fill;
         q_item.raw  = byte_fill ? BYTE_FILL : RAW_W'(byte_v);
      end else begin
         q_item.fill = word_fill;
         q_item.raw  = RAW_W'(raw_n);
      end
   end

endmodule

// File: hw/rtl/spc_fifo.sv
// ---------------------------------------------------------------------------
// spc_fifo
// Two-entry queue of classified pixels between front and back.
// ---------------------------------------------------------------------------
module spc_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  spc_pkg::spc_item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  empty,
   output spc_pkg::spc_item_type pop_item
);
   import spc_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);

   spc_item_type     mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [PTR_W:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_item = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");

endmodule

// File: hw/rtl/spc_div.sv
// ---------------------------------------------------------------------------
// spc_div
// Bit-serial signed fixed point divider, num * 2^F / den, truncated, saturated.
// ---------------------------------------------------------------------------
module spc_div #(
   parameter int FRACTION_BITS = 24
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic signed [spc_pkg::VAL_W-1:0] num,
   input  logic signed [spc_pkg::VAL_W-1:0] den,
   output logic                            done,
   output logic signed [spc_pkg::VAL_W-1:0] quo
);
   import spc_pkg::*;

   localparam int DW = VAL_W + FRACTION_BITS;
   localparam int CW = $clog2(DW + 1);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [DW-1:0]           sh_ff, sh_in;
   logic [VAL_W-1:0]        rem_ff, rem_in;
   logic [VAL_W-1:0]        d_ff, d_in;
   logic                    neg_ff, neg_in;
   logic signed [VAL_W-1:0] quo_ff, quo_in;
   logic [VAL_W:0]          rem_t;
   logic                    ge;

   assign rem_t = {rem_ff, sh_ff[DW-1]};
   assign ge    = (rem_t >= {1'b0, d_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         sh_in   = DW'(mag48(num)) << FRACTION_BITS;
         rem_in  = '0;
         d_in    = mag48(den);
         neg_in  = num[VAL_W-1] != den[VAL_W-1];
      end else if (busy_ff) begin
         rem_in = ge ? VAL_W'(rem_t - {1'b0, d_ff}) : rem_t[VAL_W-1:0];
         sh_in  = {sh_ff[DW-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(DW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = from_mag(96'(sh_in), neg_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      sh_ff  <= sh_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

// File: hw/rtl/spc_back.sv
// ---------------------------------------------------------------------------
// spc_back
// Calibration engine: radiance, gain, inverse Planck, statistics, response.
// ---------------------------------------------------------------------------
module spc_back #(
   parameter int FRACTION_BITS   = 24,
   parameter int LOG_TABLE_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  spc_pkg::spc_cfg_type  cfg,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  spc_pkg::spc_item_type q_item,
   spc_rsp_if.source             rsp
);
   import spc_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int TAB_N  = LOG_TABLE_DEPTH + 1;
   localparam int IDX_W  = $clog2(TAB_N);
   localparam int PW     = 32 + IDX_W;
   localparam int SH     = 32 - F;
   localparam int RND_SH = (F < 32) ? 31 - F : 0;
   localparam logic signed [VAL_W-1:0] LN_RND  = (F < 32) ? (48'sd1 <<< RND_SH) : 48'sd0;
   localparam logic signed [79:0]      ONE_F   = 80'sd1 <<< F;
   localparam logic [95:0]             MUL_RND = 96'd1 << (F - 1);

   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_RAD    = 13'b0000000000010,
      ST_MUL    = 13'b0000000000100,
      ST_DIV1   = 13'b0000000001000,
      ST_NORM   = 13'b0000000010000,
      ST_LOOK0  = 13'b0000000100000,
      ST_LOOK1  = 13'b0000001000000,
      ST_LOOK2  = 13'b0000010000000,
      ST_INTERP = 13'b0000100000000,
      ST_LOGV   = 13'b0001000000000,
      ST_DIV2   = 13'b0010000000000,
      ST_DIV3   = 13'b0100000000000,
      ST_DONE   = 13'b1000000000000
   } spc_state_type;

   // ln(1 + K/Depth) in Q32 from the atanh series
   function automatic logic [31:0] ln_entry(input int unsigned K, input int unsigned Depth);
      logic [63:0] z;
      logic [63:0] z2;
      logic [63:0] t;
      logic [63:0] sum;
      int unsigned J;
      z   = (64'(K) << 32) / 64'(2 * Depth + K);
      z2  = (z * z) >> 32;
      t   = z;
      sum = z;
      for (J = 3; J < 200 && t != 0; J += 2) begin
         t   = (t * z2) >> 32;
         sum = sum + t / 64'(J);
      end
      return 32'(sum << 1);
   endfunction

   logic [31:0] ln_rom [TAB_N];
   for (genvar k = 0; k < TAB_N; k++) begin : g_rom
      localparam logic [31:0] ENTRY = ln_entry(k, LOG_TABLE_DEPTH);
      assign ln_rom[k] = ENTRY;
   end

   spc_state_type           state_ff, state_in;
   spc_item_type            item_ff, item_in;
   logic signed [VAL_W-1:0] val_ff, val_in;
   logic                    dom_ff, dom_in;
   logic [VAL_W-1:0]        ma_ff, ma_in;
   logic [VAL_W-1:0]        mb_ff, mb_in;
   logic [95:0]             macc_ff, macc_in;
   logic                    mneg_ff, mneg_in;
   logic [1:0]              mcnt_ff, mcnt_in;
   logic [46:0]             nx_ff, nx_in;
   logic [5:0]              ns_ff, ns_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [31:0]             fr_ff, fr_in;
   logic [31:0]             t0_ff, t0_in;
   logic [31:0]             t1_ff, t1_in;
   logic [63:0]             dprod_ff, dprod_in;
   logic                    dneg_ff, dneg_in;
   logic signed [VAL_W-1:0] min_ff, min_in;
   logic signed [VAL_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0]        fcnt_ff, fcnt_in;
   logic                    rv_ff, rv_in;
   logic signed [VAL_W-1:0] rval_ff, rval_in;
   logic                    rfill_ff, rfill_in;
   logic                    rdom_ff, rdom_in;

   logic                    div_start;
   logic signed [VAL_W-1:0] div_num, div_den, div_quo;
   logic                    div_done;

   logic signed [63:0]      rad_prod;
   logic signed [VAL_W-1:0] rad;
   logic [63:0]             mpart;
   logic [PW-1:0]           pos;
   logic [IDX_W-1:0]        rom_addr;
   logic [31:0]             rom_q;
   logic [31:0]             diff;
   logic [32:0]             lm;
   logic signed [7:0]       pf;
   logic signed [VAL_W-1:0] lv;
   logic signed [VAL_W-1:0] lnv;
   logic signed [VAL_W-1:0] xs;
   logic signed [VAL_W-1:0] tv;
   logic                    valid_pix;
   logic signed [VAL_W-1:0] base_min, base_max;
   logic [CNT_W-1:0]        base_cnt;

   spc_div #(.FRACTION_BITS(F)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   assign rad_prod = 64'(cfg.count_scale) * 64'(item_ff.raw);
   assign rad      = sat48(80'(rad_prod) + 80'(cfg.count_offset));
   assign mpart    = 64'(ma_ff) * 64'(mb_ff[15:0]);
   assign pos      = PW'(nx_ff[45:14]) * PW'(LOG_TABLE_DEPTH);
   assign rom_addr = (state_ff == ST_LOOK1) ? idx_ff : idx_ff + 1'b1;
   assign rom_q    = ln_rom[rom_addr];
   assign diff     = (t1_ff < t0_ff) ? t0_ff - t1_ff : t1_ff - t0_ff;
   assign lm       = dneg_ff ? 33'(t0_ff) - 33'(dprod_ff[63:32])
                             : 33'(t0_ff) + 33'(dprod_ff[63:32]);
   assign pf       = 8'(46 - F) - 8'(ns_ff);
   assign lv       = 48'(pf) * 48'(signed'({1'b0, LN2_Q32})) + 48'(signed'({1'b0, lm}));
   assign lnv      = (lv + LN_RND) >>> SH;
   assign xs       = sat48(80'(div_quo) + ONE_F);
   assign tv       = sat48(80'(div_quo) - 80'(cfg.band_offset));

   assign valid_pix = !item_ff.fill && item_ff.mode != MODE_BYTE && !dom_ff;
   assign base_min  = item_ff.first ? VAL_MAX : min_ff;
   assign base_max  = item_ff.first ? VAL_MIN : max_ff;
   assign base_cnt  = item_ff.first ? '0 : fcnt_ff;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;

   always_comb begin
      state_in  = state_ff;
      item_in   = item_ff;
      val_in    = val_ff;
      dom_in    = dom_ff;
      ma_in     = ma_ff;
      mb_in     = mb_ff;
      macc_in   = macc_ff;
      mneg_in   = mneg_ff;
      mcnt_in   = mcnt_ff;
      nx_in     = nx_ff;
      ns_in     = ns_ff;
      idx_in    = idx_ff;
      fr_in     = fr_ff;
      t0_in     = t0_ff;
      t1_in     = t1_ff;
      dprod_in  = dprod_ff;
      dneg_in   = dneg_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      fcnt_in   = fcnt_ff;
      rv_in     = rv_ff && !rsp.ready;
      rval_in   = rval_ff;
      rfill_in  = rfill_ff;
      rdom_in   = rdom_ff;
      div_start = 1'b0;
      div_num   = cfg.gain_or_first_planck;
      div_den   = rad;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               item_in = q_item;
               dom_in  = 1'b0;
               val_in  = (q_item.mode == MODE_BYTE) ? VAL_W'(q_item.raw) : '0;
               if (q_item.mode == MODE_BYTE || q_item.fill) state_in = ST_DONE;
               else state_in = ST_RAD;
            end
         end
         ST_RAD: begin
            val_in  = rad;
            ma_in   = mag48(rad);
            mb_in   = mag48(cfg.gain_or_first_planck);
            mneg_in = rad[VAL_W-1] != cfg.gain_or_first_planck[VAL_W-1];
            macc_in = '0;
            mcnt_in = '0;
            case (item_ff.mode)
               MODE_REFL:  state_in = ST_MUL;
               MODE_THERM: begin
                  if (rad <= 0 || cfg.band_slope == '0) begin
                     dom_in   = 1'b1;
                     val_in   = '0;
                     state_in = ST_DONE;
                  end else begin
                     div_start = 1'b1;
                     state_in  = ST_DIV1;
                  end
               end
               default:    state_in = ST_DONE;
            endcase
         end
         ST_MUL: begin
            if (mcnt_ff == 2'd3) begin
               val_in   = from_mag((macc_ff + MUL_RND) >> F, mneg_ff);
               state_in = ST_DONE;
            end else begin
               macc_in = macc_ff + (96'(mpart) << {mcnt_ff, 4'b0000});
               mb_in   = mb_ff >> 16;
               mcnt_in = mcnt_ff + 2'd1;
            end
         end
         ST_DIV1: begin
            if (div_done) begin
               if (xs <= 0) begin
                  dom_in   = 1'b1;
                  val_in   = '0;
                  state_in = ST_DONE;
               end else begin
                  nx_in    = xs[46:0];
                  ns_in    = '0;
                  state_in = ST_NORM;
               end
            end
         end
         ST_NORM: begin
            // leading one walks up to bit 46
            if (nx_ff[46]) begin
               state_in = ST_LOOK0;
            end else begin
               nx_in = nx_ff << 1;
               ns_in = ns_ff + 6'd1;
            end
         end
         ST_LOOK0: begin
            idx_in   = (pos[PW-1:32] >= IDX_W'(LOG_TABLE_DEPTH))
                       ? IDX_W'(LOG_TABLE_DEPTH - 1) : pos[PW-1:32];
            fr_in    = pos[31:0];
            state_in = ST_LOOK1;
         end
         ST_LOOK1: begin
            t0_in    = rom_q;
            state_in = ST_LOOK2;
         end
         ST_LOOK2: begin
            t1_in    = rom_q;
            state_in = ST_INTERP;
         end
         ST_INTERP: begin
            dneg_in  = t1_ff < t0_ff;
            dprod_in = 64'(diff) * 64'(fr_ff);
            state_in = ST_LOGV;
         end
         ST_LOGV: begin
            if (lnv == '0) begin
               dom_in   = 1'b1;
               val_in   = '0;
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1;
               div_num   = cfg.second_planck;
               div_den   = lnv;
               state_in  = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_done) begin
               div_start = 1'b1;
               div_num   = tv;
               div_den   = cfg.band_slope;
               state_in  = ST_DIV3;
            end
         end
         ST_DIV3: begin
            if (div_done) begin
               val_in   = div_quo;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rv_ff || rsp.ready) begin
               rv_in    = 1'b1;
               rval_in  = val_ff;
               rfill_in = item_ff.fill;
               rdom_in  = dom_ff;
               min_in   = base_min;
               max_in   = base_max;
               fcnt_in  = base_cnt;
               if (item_ff.fill) begin
                  if (base_cnt != CNT_MAX) fcnt_in = base_cnt + 1'b1;
               end else if (valid_pix) begin
                  if (val_ff < base_min) min_in = val_ff;
                  if (val_ff > base_max) max_in = val_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         min_ff   <= VAL_MAX;
         max_ff   <= VAL_MIN;
         fcnt_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff   <= min_in;
         max_ff   <= max_in;
         fcnt_ff  <= fcnt_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      val_ff   <= val_in;
      dom_ff   <= dom_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      macc_ff  <= macc_in;
      mneg_ff  <= mneg_in;
      mcnt_ff  <= mcnt_in;
      nx_ff    <= nx_in;
      ns_ff    <= ns_in;
      idx_ff   <= idx_in;
      fr_ff    <= fr_in;
      t0_ff    <= t0_in;
      t1_ff    <= t1_in;
      dprod_ff <= dprod_in;
      dneg_ff  <= dneg_in;
      rval_ff  <= rval_in;
      rfill_ff <= rfill_in;
      rdom_ff  <= rdom_in;
   end

   assign rsp.valid            = rv_ff;
   assign rsp.calibrated_value = rval_ff;
   assign rsp.is_fill          = rfill_ff;
   assign rsp.out_of_domain    = rdom_ff;
   assign rsp.running_min      = min_ff;
   assign rsp.running_max      = max_ff;
   assign rsp.fill_total       = fcnt_ff;

endmodule

// File: hw/rtl/satellite_pixel_calibration_core.sv
// ---------------------------------------------------------------------------
// satellite_pixel_calibration_core
// Per-pixel radiometric calibration with running image statistics.
// ---------------------------------------------------------------------------
// One request is one raw pixel count; one response follows for each request,
// in order. A front stage classifies the pixel (fill detection, byte or word
// count) and queues it in a two-entry queue; a back engine computes the value
// one pixel at a time. Byte and fill pixels go from the idle state straight to
// the response state; plain mode passes the radiance state first, and
// reflective mode then forms the gain product from three 48x16 partial
// products. Thermal mode uses the bit-serial divider, 48+FRACTION_BITS
// quotient bits per divide, three times, and normalizes the quotient before
// the log table lookup and interpolation. A response that waits holds the
// back engine in its last state. The front keeps taking requests while the
// back works or a response waits, until the queue is full.
module satellite_pixel_calibration_core #(
   parameter int FRACTION_BITS   = 24,
   parameter int RAW_WIDTH       = 16,
   parameter int LOG_TABLE_DEPTH = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   spc_req_if.sink                          req_bus,
   spc_rsp_if.source                        rsp_bus,
   input  logic                             csr_we,
   input  logic [spc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spc_pkg::VAL_W-1:0]        csr_wdata
);
   import spc_pkg::*;

   spc_cfg_type  cfg_ff, cfg_in;
   spc_item_type push_item, pop_item;
   logic         q_push, q_pop, q_full, q_empty;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (spc_csr_type'(csr_index))
            CSR_MODE:       cfg_in.mode                 = spc_mode_type'(csr_wdata[1:0]);
            CSR_FILL_CODE:  cfg_in.fill_code            = csr_wdata[RAW_W-1:0];
            CSR_SCALE:      cfg_in.count_scale          = csr_wdata;
            CSR_OFFSET:     cfg_in.count_offset         = csr_wdata;
            CSR_GAIN:       cfg_in.gain_or_first_planck = csr_wdata;
            CSR_C2:         cfg_in.second_planck        = csr_wdata;
            CSR_BAND_OFF:   cfg_in.band_offset          = csr_wdata;
            CSR_BAND_SLOPE: cfg_in.band_slope           = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode                 <= MODE_SCALED;
         cfg_ff.fill_code            <= '0;
         cfg_ff.count_scale          <= 48'sd1 <<< FRACTION_BITS;
         cfg_ff.count_offset         <= '0;
         cfg_ff.gain_or_first_planck <= '0;
         cfg_ff.second_planck        <= '0;
         cfg_ff.band_offset          <= '0;
         cfg_ff.band_slope           <= 48'sd1 <<< FRACTION_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spc_front #(.RAW_WIDTH(RAW_WIDTH)) u_front (
      .req    (req_bus),
      .cfg    (cfg_ff),
      .q_full (q_full),
      .q_push (q_push),
      .q_item (push_item)
   );

   spc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_item  (pop_item)
   );

   spc_back #(
      .FRACTION_BITS   (FRACTION_BITS),
      .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .q_item  (pop_item),
      .rsp     (rsp_bus)
   );

   a_dom_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.out_of_domain |-> rsp_bus.calibrated_value == '0)
      else $error("domain error with nonzero value");

   a_fill_no_dom: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.is_fill |-> !rsp_bus.out_of_domain)
      else $error("fill pixel flagged out of domain");

   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.running_min <= rsp_bus.running_max)
                     || (rsp_bus.running_min == VAL_MAX && rsp_bus.running_max == VAL_MIN))
      else $error("running minimum above running maximum");

endmodule
